// ----- design/mtxk_pkg.sv -----
//==============================================================================
// MT19937 keystream XOR - shared package
// Table geometry, generator constants, register map, control state encoding
// and the combinational twist and tempering functions.
//==============================================================================
`default_nettype none

package mtxk_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned TW_N    = 624;
    localparam int unsigned TW_M    = 397;
    localparam int unsigned IDX_W   = 10;
    localparam int unsigned PADDR_W = 3;

    localparam logic [IDX_W-1:0]  IDX_ZERO  = IDX_W'(0);
    localparam logic [IDX_W-1:0]  IDX_ONE   = IDX_W'(1);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(TW_N - 1);
    localparam logic [IDX_W-1:0]  IDX_M     = IDX_W'(TW_M);
    localparam logic [IDX_W-1:0]  IDX_SPAN  = IDX_W'(TW_N - TW_M);

    localparam logic [WORD_W-1:0] TW_MATRIX    = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] TW_UPPER     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] TW_LOWER     = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] TW_INIT_MULT = 32'd1812433253;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;
    localparam logic [WORD_W-1:0] SEED_RESET   = 32'd1337;

    localparam logic [PADDR_W-3:0] REG_SEED = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_ADD,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_CALC,
        ST_DONE
    } state_t;

    function automatic logic [WORD_W-1:0] twist_word(
        input logic [WORD_W-1:0] cur,
        input logic [WORD_W-1:0] nxt,
        input logic [WORD_W-1:0] far
    );
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] v;
        y = (cur & TW_UPPER) | (nxt & TW_LOWER);
        v = far ^ (y >> 1);
        if (y[0]) begin
            v = v ^ TW_MATRIX;
        end
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

`default_nettype wire

// ----- design/mt19937_xor_keystream.sv -----
// Each word takes three reads of the table RAM's single read port (the current
// entry, the next one and the one M ahead), captured in RD1, RD2 and CALC; the
// result is registered out of CALC, or out of DONE while the receiver stalls. A
// restart, and the first request after reset, first seed the table. A new request
// is taken once the last is through. Reset sets only control state and the seed.
//==============================================================================
// MT19937 keystream XOR
// XORs each request word with the next tempered MT19937 output. The table
// is twisted one entry per word, in place, in a 624 x 32 RAM.
//==============================================================================
`default_nettype none

module mt19937_xor_keystream (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mtxk_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [31:0]                   s_data_word,
    input  wire logic                          s_restart,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [31:0]                   m_result_word
);

    mtxk_pkg::state_t state_reg;
    mtxk_pkg::state_t state_next;

    logic [31:0]                  seed_reg;
    logic                         seeded_reg;
    logic [mtxk_pkg::IDX_W-1:0]   k_reg;
    logic [mtxk_pkg::IDX_W-1:0]   sidx_reg;
    logic [31:0]                  data_reg;
    logic [31:0]                  a_reg;
    logic [31:0]                  b_reg;
    logic [31:0]                  prev_reg;
    logic [31:0]                  prod_reg;
    logic [31:0]                  hold_reg;
    logic                         m_valid_reg;
    logic [31:0]                  m_result_reg;

    logic                         accept;
    logic                         reseed;
    logic                         out_free;
    logic                         cfg_wr;
    logic [mtxk_pkg::PADDR_W-3:0] cfg_idx;
    logic [mtxk_pkg::IDX_W-1:0]   k_inc;
    logic [mtxk_pkg::IDX_W-1:0]   k_far;
    logic [31:0]                  mix;
    logic [31:0]                  seed_sum;
    logic [31:0]                  twist_val;
    logic [31:0]                  out_val;
    logic                         load_calc;
    logic                         load_done;

    logic                         ram_we;
    logic [mtxk_pkg::IDX_W-1:0]   ram_waddr;
    logic [31:0]                  ram_wdata;
    logic [mtxk_pkg::IDX_W-1:0]   ram_raddr;
    logic [31:0]                  ram_rdata;

    mtxk_ram #(
        .WIDTH (mtxk_pkg::WORD_W),
        .DEPTH (mtxk_pkg::TW_N)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[mtxk_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready && (cfg_idx == mtxk_pkg::REG_SEED);
    assign prdata  = (cfg_idx == mtxk_pkg::REG_SEED) ? seed_reg : 32'd0;

    assign accept   = s_valid && s_ready;
    assign reseed   = s_restart || !seeded_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign k_inc = (k_reg == mtxk_pkg::IDX_LAST) ? mtxk_pkg::IDX_ZERO : k_reg + mtxk_pkg::IDX_ONE;
    assign k_far = (k_reg < mtxk_pkg::IDX_SPAN) ? k_reg + mtxk_pkg::IDX_M
                                                : k_reg - mtxk_pkg::IDX_SPAN;

    assign mix       = prev_reg ^ (prev_reg >> 30);
    assign seed_sum  = prod_reg + {{(32 - mtxk_pkg::IDX_W){1'b0}}, sidx_reg};
    assign twist_val = mtxk_pkg::twist_word(a_reg, b_reg, ram_rdata);
    assign out_val   = data_reg ^ mtxk_pkg::temper(twist_val);

    assign m_valid       = m_valid_reg;
    assign m_result_word = m_result_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mtxk_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = reseed ? mtxk_pkg::ST_SEED_MUL : mtxk_pkg::ST_RD1;
                end
            end
            mtxk_pkg::ST_SEED_MUL: begin
                state_next = mtxk_pkg::ST_SEED_ADD;
            end
            mtxk_pkg::ST_SEED_ADD: begin
                state_next = (sidx_reg == mtxk_pkg::IDX_LAST) ? mtxk_pkg::ST_RD0
                                                              : mtxk_pkg::ST_SEED_MUL;
            end
            mtxk_pkg::ST_RD0: begin
                state_next = mtxk_pkg::ST_RD1;
            end
            mtxk_pkg::ST_RD1: begin
                state_next = mtxk_pkg::ST_RD2;
            end
            mtxk_pkg::ST_RD2: begin
                state_next = mtxk_pkg::ST_CALC;
            end
            mtxk_pkg::ST_CALC: begin
                if (!out_free) begin
                    state_next = mtxk_pkg::ST_DONE;
                end else if (accept) begin
                    state_next = reseed ? mtxk_pkg::ST_SEED_MUL : mtxk_pkg::ST_RD1;
                end else begin
                    state_next = mtxk_pkg::ST_IDLE;
                end
            end
            mtxk_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = mtxk_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mtxk_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        load_calc = 1'b0;
        load_done = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = k_reg;
        ram_wdata = twist_val;
        ram_raddr = k_reg;
        case (state_reg)
            mtxk_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            mtxk_pkg::ST_SEED_MUL: begin
                if (sidx_reg == mtxk_pkg::IDX_ONE) begin
                    ram_we    = 1'b1;
                    ram_waddr = mtxk_pkg::IDX_ZERO;
                    ram_wdata = prev_reg;
                end
            end
            mtxk_pkg::ST_SEED_ADD: begin
                ram_we    = 1'b1;
                ram_waddr = sidx_reg;
                ram_wdata = seed_sum;
            end
            mtxk_pkg::ST_RD0: begin
                ram_raddr = k_reg;
            end
            mtxk_pkg::ST_RD1: begin
                ram_raddr = k_inc;
            end
            mtxk_pkg::ST_RD2: begin
                ram_raddr = k_far;
            end
            mtxk_pkg::ST_CALC: begin
                s_ready   = out_free;
                load_calc = out_free;
                ram_we    = 1'b1;
                ram_raddr = k_inc;
            end
            mtxk_pkg::ST_DONE: begin
                load_done = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mtxk_pkg::ST_IDLE;
            seed_reg    <= mtxk_pkg::SEED_RESET;
            seeded_reg  <= 1'b0;
            k_reg       <= mtxk_pkg::IDX_ZERO;
            sidx_reg    <= mtxk_pkg::IDX_ONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                seed_reg <= pwdata;
            end
            if (accept && reseed) begin
                seeded_reg <= 1'b1;
                k_reg      <= mtxk_pkg::IDX_ZERO;
                sidx_reg   <= mtxk_pkg::IDX_ONE;
            end else begin
                if (state_reg == mtxk_pkg::ST_SEED_ADD) begin
                    sidx_reg <= sidx_reg + mtxk_pkg::IDX_ONE;
                end
                if (state_reg == mtxk_pkg::ST_CALC) begin
                    k_reg <= k_inc;
                end
            end
            if (load_calc || load_done) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= s_data_word;
            if (reseed) begin
                prev_reg <= seed_reg;
            end
        end
        case (state_reg)
            mtxk_pkg::ST_SEED_MUL: begin
                prod_reg <= mix * mtxk_pkg::TW_INIT_MULT;
            end
            mtxk_pkg::ST_SEED_ADD: begin
                prev_reg <= seed_sum;
            end
            mtxk_pkg::ST_RD1: begin
                a_reg <= ram_rdata;
            end
            mtxk_pkg::ST_RD2: begin
                b_reg <= ram_rdata;
            end
            mtxk_pkg::ST_CALC: begin
                hold_reg <= out_val;
            end
            default: begin
                hold_reg <= hold_reg;
            end
        endcase
        if (load_calc) begin
            m_result_reg <= out_val;
        end else if (load_done) begin
            m_result_reg <= hold_reg;
        end
    end

endmodule

`default_nettype wire

// ----- design/mtxk_ram.sv -----
//==============================================================================
// Generic RAM
// One write port and one read port, read data registered (ready the cycle after the address).
//==============================================================================
`default_nettype none

module mtxk_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- design/mtxk_checker.sv -----
//==============================================================================
// MT19937 keystream XOR - port checker
// Watches the top-level ports for handshake and sequencing errors.
//==============================================================================
`default_nettype none

module mtxk_port_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        pready,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_result_word
);

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_result_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_result_word))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous one in work");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_valid && s_ready, 2))
        else $error("result appeared two cycles after request");

    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind mt19937_xor_keystream mtxk_port_checker u_mtxk_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .pready        (pready),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_word (m_result_word)
);

`default_nettype wire
